// ===== sv/bcr_pkg.sv =====
// ----------------------------------------------------------------------------
// bcr_pkg: shared types and constants for backlash compensation ramp
// Widths, register codes, phase codes, sequencer states and datapath helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bcr_pkg;

  localparam int FRAC_BITS = 24;
  localparam int OFS_W     = FRAC_BITS + 5;
  localparam int VEL_W     = FRAC_BITS + 12;
  localparam int BKL_W     = FRAC_BITS + 5;
  localparam int VLIM_W    = FRAC_BITS + 11;
  localparam int ALIM_W    = FRAC_BITS + 17;
  localparam int TICK_W    = 32;
  localparam int CFG_DW    = ALIM_W;
  localparam int CFG_IW    = 2;
  localparam int PHASE_W   = 3;
  localparam int DIR_W     = 2;
  localparam int W         = 64;
  localparam int HALF_W    = W / 2;
  localparam int CNT_W     = $clog2(W + 1);
  localparam int SCALE_W   = 7;

  localparam logic [W-1:0] STOP_CAP   = W'(1) << 60;
  localparam logic [SCALE_W-1:0] PCT_NUM = SCALE_W'(105);
  // ceil(2^70 / 100): floor(x / 100) = (x * PCT_RECIP) >> 70 for any x below 2^63
  localparam int           PCT_SHIFT  = 70;
  localparam logic [W-1:0] PCT_RECIP  = 64'd11805916207174113035;

  localparam logic [VLIM_W-1:0] VLIM_RST = VLIM_W'(10) << FRAC_BITS;
  localparam logic [ALIM_W-1:0] ALIM_RST = ALIM_W'(100) << FRAC_BITS;
  localparam logic [TICK_W-1:0] TICK_RST = TICK_W'(4294967);

  localparam logic signed [W-1:0] OFS_MAX = (W'(1) <<< (OFS_W - 1)) - W'(1);
  localparam logic signed [W-1:0] OFS_MIN = -OFS_MAX - W'(1);
  localparam logic signed [W-1:0] VEL_MAX = (W'(1) <<< (VEL_W - 1)) - W'(1);
  localparam logic signed [W-1:0] VEL_MIN = -VEL_MAX - W'(1);

  typedef enum logic [CFG_IW-1:0] {
    CFG_BACKLASH = 2'd0,
    CFG_VLIMIT   = 2'd1,
    CFG_ALIMIT   = 2'd2,
    CFG_TICK     = 2'd3
  } bcr_cfg_idx_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_ON_TARGET = 3'd0,
    PH_RAMP_UP   = 3'd1,
    PH_CONSTANT  = 3'd2,
    PH_RAMP_DOWN = 3'd3,
    PH_SNAP      = 3'd4,
    PH_CLEARED   = 3'd6
  } bcr_phase_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_VMAX, ST_AMAX, ST_SETUP, ST_DSVEL, ST_DV, ST_SQ1, ST_SD1,
    ST_DECIDE, ST_ACC_DN, ST_ACC_UP, ST_SQ2, ST_SD2, ST_CHOOSE, ST_WRITE, ST_DONE
  } bcr_state_t;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
    return x < 0 ? W'(-x) : W'(x);
  endfunction

  // trunc(|x| * T / 2^(32+extra)) with the sign of x restored
  function automatic logic signed [W-1:0] tick_scale(input logic [2*W-1:0] prod,
                                                     input logic extra,
                                                     input logic neg);
    logic [W-1:0] r;
    r = prod[W+HALF_W-1:HALF_W] >> extra;
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [W-1:0] stop_cap(input logic [W-1:0] q,
                                                   input logic ovf);
    return (ovf || q > STOP_CAP) ? $signed(STOP_CAP) : $signed(q);
  endfunction

  function automatic logic signed [OFS_W-1:0] clamp_ofs(input logic signed [W-1:0] x);
    logic signed [W-1:0] y;
    y = (x > OFS_MAX) ? OFS_MAX : ((x < OFS_MIN) ? OFS_MIN : x);
    return OFS_W'(y);
  endfunction

  function automatic logic signed [VEL_W-1:0] clamp_vel(input logic signed [W-1:0] x);
    logic signed [W-1:0] y;
    y = (x > VEL_MAX) ? VEL_MAX : ((x < VEL_MIN) ? VEL_MIN : x);
    return VEL_W'(y);
  endfunction

endpackage

`default_nettype wire

// ===== sv/bcr_if.sv =====
// ----------------------------------------------------------------------------
// bcr_if: channel interfaces for backlash compensation ramp
// Tick request, result and configuration write channels, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic signed [bcr_pkg::DIR_W-1:0]     move_dir;
  modport source (output valid, req_type, move_dir, input ready);
  modport sink   (input valid, req_type, move_dir, output ready);
endinterface

interface bcr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bcr_pkg::OFS_W-1:0]     filtered_offset;
  logic signed [bcr_pkg::VEL_W-1:0]     comp_velocity;
  logic [bcr_pkg::PHASE_W-1:0]          phase;
  modport source (output valid, filtered_offset, comp_velocity, phase, input ready);
  modport sink   (input valid, filtered_offset, comp_velocity, phase, output ready);
endinterface

interface bcr_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [bcr_pkg::CFG_IW-1:0]           index;
  logic [bcr_pkg::CFG_DW-1:0]           data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/bcr_mul.sv =====
// ----------------------------------------------------------------------------
// bcr_mul: shared 64x64 multiplier built on one 32x32 product per cycle
// Four partial products, each registered, then accumulated into 128 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module bcr_mul (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [bcr_pkg::W-1:0]       op_a,
  input  wire logic [bcr_pkg::W-1:0]       op_b,
  output logic                             done,
  output logic [2*bcr_pkg::W-1:0]          prod
);
  import bcr_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [2:0]        cnt_r;
  logic [W-1:0]      a_r;
  logic [W-1:0]      b_r;
  logic [W-1:0]      pp_r;
  logic [2*W-1:0]    acc_r;
  logic [HALF_W-1:0] a_part;
  logic [HALF_W-1:0] b_part;
  logic [7:0]        sh;

  // step order: lo*lo, lo*hi, hi*lo, hi*hi
  assign a_part = cnt_r[1] ? a_r[W-1:HALF_W] : a_r[HALF_W-1:0];
  assign b_part = cnt_r[0] ? b_r[W-1:HALF_W] : b_r[HALF_W-1:0];

  always_comb begin
    unique case (cnt_r)
      3'd1:    sh = 8'd0;
      3'd4:    sh = 8'(W);
      default: sh = 8'(HALF_W);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= op_a;
        b_r    <= op_b;
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r != 3'd4) begin
          pp_r <= W'(a_part * b_part);
        end
        if (cnt_r != 3'd0) begin
          acc_r <= acc_r + ({{W{1'b0}}, pp_r} << sh);
        end
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

// ===== sv/bcr_div.sv =====
// ----------------------------------------------------------------------------
// bcr_div: shared restoring divider, 128 by 64 bits, one quotient bit a cycle
// Flags overflow at once when the high word is not below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module bcr_div (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [bcr_pkg::W-1:0]   num_hi,
  input  wire logic [bcr_pkg::W-1:0]   num_lo,
  input  wire logic [bcr_pkg::W-1:0]   den,
  output logic                         done,
  output logic [bcr_pkg::W-1:0]        quo,
  output logic                         ovf
);
  import bcr_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic             ovf_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     lo_r;
  logic [W-1:0]     quo_r;
  logic [W-1:0]     den_r;
  logic [W:0]       trial;
  logic             fits;

  assign trial = {rem_r, lo_r[W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        den_r <= den;
        rem_r <= num_hi;
        lo_r  <= num_lo;
        quo_r <= '0;
        cnt_r <= CNT_W'(W);
        ovf_r <= num_hi >= den;
        if (num_hi >= den) begin
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= fits ? W'(trial - {1'b0, den_r}) : trial[W-1:0];
        lo_r  <= lo_r << 1;
        quo_r <= {quo_r[W-2:0], fits};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign ovf  = ovf_r;

endmodule

`default_nettype wire

// ===== sv/backlash_comp_ramp.sv =====
// ----------------------------------------------------------------------------
// backlash_comp_ramp: per-axis backlash compensation with trapezoidal ramp
// Sequencer driving one shared multiplier and one shared divider.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transfer per servo tick (req_type 0, move_dir -1/0/1) or a
//            clear request (req_type 1) after an estop.
//   out_ch : one transfer per request: filtered_offset, comp_velocity, phase.
//   cfg_ch : register writes (backlash, velocity limit, accel limit, tick
//            period); always ready, write only while the block is idle.
// Sequence: a clear request needs no shared unit; a servo tick that finds
//   the axis on target takes only the two limit scalings, and a tick that
//   takes a ramp-up or constant step runs two stop-distance divisions. Every
//   product (both 1.05 limit scalings by reciprocal, each tick-period product
//   and each square) runs on the shared 32x32 multiplier; each stop-distance
//   division runs on the one-bit-per-cycle divider and ends early when the
//   quotient overflows.
// Throughput: one request at a time; in_ch.ready is high only in idle.
//   The result sits in an output register, so a new request is taken while
//   the previous result still waits for the receiver.
// Reset: rst_n low zeroes the target, offset and velocity and loads the
//   default limits; no result is pending.
// Stall: while out_ch.ready is low a finished result holds; a second finished
//   result waits in the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module backlash_comp_ramp (
  input  wire logic clk,
  input  wire logic rst_n,
  bcr_in_if.sink    in_ch,
  bcr_out_if.source out_ch,
  bcr_cfg_if.sink   cfg_ch
);
  import bcr_pkg::*;

  // configuration registers
  logic [BKL_W-1:0]  bkl_r;
  logic [VLIM_W-1:0] vlim_r;
  logic [ALIM_W-1:0] alim_r;
  logic [TICK_W-1:0] tick_r;

  // axis state
  logic signed [OFS_W-1:0] tgt_r;
  logic signed [OFS_W-1:0] ofs_r;
  logic signed [VEL_W-1:0] vel_r;

  // working registers
  bcr_state_t        state_r, state_nxt;
  logic              launch_r, launch_nxt;
  logic [DIR_W-1:0]  dbits_r;
  logic              neg_r;
  logic signed [W-1:0] vmax_r;
  logic [W-1:0]      amax_r;
  logic signed [W-1:0] s_r, u_r, dv_r, dsvel_r, dsacc_r, sd_r, step_r;
  bcr_phase_t        phase_r;

  // output register
  logic                    out_valid_r;
  logic signed [OFS_W-1:0] out_ofs_r;
  logic signed [VEL_W-1:0] out_vel_r;
  bcr_phase_t              out_phase_r;

  // shared units
  logic              mul_start, mul_done;
  logic [W-1:0]      mul_a, mul_b;
  logic [2*W-1:0]    mul_prod;
  logic              div_start, div_done, div_ovf;
  logic [W-1:0]      div_hi, div_lo, div_den, div_quo;

  logic              in_xfer, out_adv;
  logic signed [W-1:0] w_sum;
  logic signed [W-1:0] scaled;
  logic [W-1:0]      pct_quo;
  logic              sc_extra, sc_neg;
  logic signed [OFS_W-1:0] half, tgt_new;
  logic signed [W-1:0] diff, s_new;

  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_adv      = !out_valid_r || out_ch.ready;

  // ---------------- configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bkl_r  <= '0;
      vlim_r <= VLIM_RST;
      alim_r <= ALIM_RST;
      tick_r <= TICK_RST;
    end else if (cfg_ch.valid) begin
      unique case (bcr_cfg_idx_t'(cfg_ch.index))
        CFG_BACKLASH: bkl_r  <= cfg_ch.data[BKL_W-1:0];
        CFG_VLIMIT:   vlim_r <= cfg_ch.data[VLIM_W-1:0];
        CFG_ALIMIT:   alim_r <= cfg_ch.data[ALIM_W-1:0];
        CFG_TICK:     tick_r <= cfg_ch.data[TICK_W-1:0];
      endcase
    end
  end

  // ---------------- target and distance for the new tick
  assign half = $signed({1'b0, bkl_r[BKL_W-1:1]});
  always_comb begin
    if (dbits_r == DIR_W'(1)) begin
      tgt_new = half;
    end else if (dbits_r[DIR_W-1]) begin
      tgt_new = -half;
    end else begin
      tgt_new = tgt_r;
    end
  end
  assign diff  = W'(tgt_new) - W'(ofs_r);
  assign s_new = diff < 0 ? -diff : diff;
  assign w_sum = u_r + dv_r;

  // ---------------- shared unit operands
  always_comb begin
    mul_a    = '0;
    mul_b    = W'(tick_r);
    sc_extra = 1'b0;
    sc_neg   = 1'b0;
    unique case (state_r)
      // scale a limit by 105, then divide by 100 through the reciprocal
      ST_VMAX: begin
        mul_a = W'({{SCALE_W{1'b0}}, vlim_r} * W'(PCT_NUM));
        mul_b = PCT_RECIP;
      end
      ST_AMAX: begin
        mul_a = W'({{SCALE_W{1'b0}}, alim_r} * W'(PCT_NUM));
        mul_b = PCT_RECIP;
      end
      ST_DSVEL: begin
        mul_a  = mag(u_r);
        sc_neg = u_r[W-1];
      end
      ST_DV:    mul_a = amax_r;
      ST_SQ1, ST_SQ2: begin
        mul_a = mag(w_sum);
        mul_b = mag(w_sum);
      end
      ST_ACC_DN, ST_ACC_UP: begin
        mul_a    = mag(dv_r);
        sc_extra = 1'b1;
        sc_neg   = dv_r[W-1];
      end
      default: ;
    endcase
  end
  assign scaled  = tick_scale(mul_prod, sc_extra, sc_neg);
  assign pct_quo = W'(mul_prod[2*W-1:PCT_SHIFT]);

  // the divider only ever takes a square over twice the acceleration
  assign div_hi  = mul_prod[2*W-1:W];
  assign div_lo  = mul_prod[W-1:0];
  assign div_den = amax_r << 1;

  bcr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  bcr_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num_hi (div_hi),
    .num_lo (div_lo),
    .den    (div_den),
    .done   (div_done),
    .quo    (div_quo),
    .ovf    (div_ovf)
  );

  // ---------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      launch_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= launch_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    launch_nxt = launch_r;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = in_ch.req_type ? ST_DONE : ST_VMAX;
        end
      end
      ST_SD1, ST_SD2: begin
        // launch once, then wait for the divider
        div_start  = !launch_r;
        launch_nxt = 1'b1;
        if (div_done) begin
          launch_nxt = 1'b0;
          unique case (state_r)
            ST_SD1:  state_nxt = ST_DECIDE;
            default: state_nxt = ST_CHOOSE;
          endcase
        end
      end
      ST_VMAX, ST_AMAX, ST_DSVEL, ST_DV, ST_SQ1, ST_SQ2, ST_ACC_DN, ST_ACC_UP: begin
        mul_start  = !launch_r;
        launch_nxt = 1'b1;
        if (mul_done) begin
          launch_nxt = 1'b0;
          unique case (state_r)
            ST_VMAX:   state_nxt = ST_AMAX;
            ST_AMAX:   state_nxt = ST_SETUP;
            ST_DSVEL:  state_nxt = ST_DV;
            ST_DV:     state_nxt = ST_SQ1;
            ST_SQ1:    state_nxt = ST_SD1;
            ST_SQ2:    state_nxt = ST_SD2;
            ST_ACC_DN: state_nxt = ST_WRITE;
            default:   state_nxt = ST_SQ2;
          endcase
        end
      end
      ST_SETUP:  state_nxt = (s_new > 0) ? ST_DSVEL : ST_DONE;
      ST_DECIDE: begin
        if (s_r <= sd_r + dsvel_r) begin
          state_nxt = (u_r > dv_r) ? ST_ACC_DN : ST_DONE;
        end else begin
          state_nxt = ST_ACC_UP;
        end
      end
      ST_CHOOSE: state_nxt = ST_WRITE;
      ST_WRITE:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_adv) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r <= '0;
      ofs_r <= '0;
      vel_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            dbits_r <= in_ch.move_dir;
            if (in_ch.req_type) begin
              tgt_r   <= '0;
              ofs_r   <= '0;
              vel_r   <= '0;
              phase_r <= PH_CLEARED;
            end
          end
        end
        ST_VMAX: if (mul_done) vmax_r <= $signed(pct_quo);
        ST_AMAX: begin
          if (mul_done) begin
            // a zero limit still needs one lsb of acceleration
            amax_r <= (pct_quo == '0) ? W'(1) : pct_quo;
          end
        end
        ST_SETUP: begin
          tgt_r   <= tgt_new;
          neg_r   <= diff < 0;
          s_r     <= s_new;
          u_r     <= (diff < 0) ? -W'(vel_r) : W'(vel_r);
          phase_r <= PH_ON_TARGET;
        end
        ST_DSVEL: if (mul_done) dsvel_r <= scaled;
        ST_DV:    if (mul_done) dv_r <= scaled;
        ST_SD1, ST_SD2: if (div_done) sd_r <= stop_cap(div_quo, div_ovf);
        ST_DECIDE: begin
          if (s_r <= sd_r + dsvel_r) begin
            if (!(u_r > dv_r)) begin
              // final snap onto the target
              vel_r   <= '0;
              ofs_r   <= tgt_r;
              phase_r <= PH_SNAP;
            end
          end else if (w_sum > vmax_r) begin
            dv_r <= vmax_r - u_r;
          end
        end
        ST_ACC_DN: begin
          if (mul_done) begin
            u_r     <= u_r - dv_r;
            step_r  <= dsvel_r - scaled;
            phase_r <= PH_RAMP_DOWN;
          end
        end
        ST_ACC_UP: if (mul_done) dsacc_r <= scaled;
        ST_CHOOSE: begin
          if (s_r > sd_r + dsvel_r + dsacc_r) begin
            u_r     <= w_sum;
            step_r  <= dsvel_r + dsacc_r;
            phase_r <= PH_RAMP_UP;
          end else begin
            step_r  <= dsvel_r;
            phase_r <= PH_CONSTANT;
          end
        end
        ST_WRITE: begin
          vel_r <= clamp_vel(neg_r ? -u_r : u_r);
          ofs_r <= clamp_ofs(W'(ofs_r) + (neg_r ? -step_r : step_r));
        end
        default: ;
      endcase
    end
  end

  // ---------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_adv) begin
      out_valid_r <= 1'b1;
      out_ofs_r   <= ofs_r;
      out_vel_r   <= vel_r;
      out_phase_r <= phase_r;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.filtered_offset = out_ofs_r;
  assign out_ch.comp_velocity   = out_vel_r;
  assign out_ch.phase           = out_phase_r;

endmodule

`default_nettype wire

// ===== sv/bcr_check.sv =====
// ----------------------------------------------------------------------------
// bcr_check: port-level checks for backlash compensation ramp
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bcr_check (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic signed [bcr_pkg::OFS_W-1:0] out_offset,
  input wire logic signed [bcr_pkg::VEL_W-1:0] out_velocity,
  input wire logic [bcr_pkg::PHASE_W-1:0]      out_phase
);
  import bcr_pkg::*;

  // one request at a time: ready drops after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_offset) &&
    $stable(out_velocity) && $stable(out_phase))
    else $error("stalled result changed");

  a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase == PH_CLEARED |-> out_offset == '0 && out_velocity == '0)
    else $error("clear left nonzero state");

  a_snap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase == PH_SNAP |-> out_velocity == '0)
    else $error("snap with nonzero velocity");

endmodule

bind backlash_comp_ramp bcr_check u_bcr_check (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_offset   (out_ch.filtered_offset),
  .out_velocity (out_ch.comp_velocity),
  .out_phase    (out_ch.phase)
);

`default_nettype wire
